/* rtl/core/spi_lse_pkg.sv */
// shared types and constants for the spi pin level shift engine
package spi_lse_pkg;

  localparam int unsigned MaxWordBitsDefault = 31;
  localparam int unsigned CountW             = 5;
  localparam int unsigned CfgIdxW            = 2;
  localparam int unsigned CfgDataW           = 5;
  localparam int unsigned ActionW            = 2;

  localparam logic [CountW-1:0] WordBitsReset = CountW'(8);

  typedef enum logic [ActionW-1:0] {
    ActClock = 2'd0,
    ActMosi  = 2'd1,
    ActQuery = 2'd2,
    ActRsvd  = 2'd3
  } action_e;

  typedef enum logic [CfgIdxW-1:0] {
    RegPolarity = 2'd0,
    RegPhase    = 2'd1,
    RegWordBits = 2'd2,
    RegNone     = 2'd3
  } reg_idx_e;

  // one configuration write request
  typedef struct packed {
    logic                en;
    logic [CfgIdxW-1:0]  index;
    logic [CfgDataW-1:0] data;
  } cfg_wr_t;

endpackage

/* rtl/core/spi_lse_core.sv */
// pin state, shift registers and per-event update of the spi slave engine
module spi_lse_core #(
  parameter int unsigned MaxWordBits = spi_lse_pkg::MaxWordBitsDefault
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  spi_lse_pkg::cfg_wr_t                cfg_wr_i,
  input  logic                                step_i,
  input  logic [spi_lse_pkg::ActionW-1:0]     action_i,
  input  logic                                level_i,
  input  logic [MaxWordBits-1:0]              reply_word_i,
  output logic                                miso_level_o,
  output logic                                word_done_o,
  output logic [MaxWordBits-1:0]              sent_word_o
);

  localparam int unsigned CntW = spi_lse_pkg::CountW;

  logic            pol_q, pol_d;
  logic            pha_q, pha_d;
  logic [CntW-1:0] wbits_q, wbits_d;

  logic                   clk_lvl_q, clk_lvl_d;
  logic                   mosi_q, mosi_d;
  logic                   miso_q, miso_d;
  logic                   in_word_q, in_word_d;
  logic [MaxWordBits-1:0] tx_q, tx_d;
  logic [CntW-1:0]        tx_cnt_q, tx_cnt_d;
  logic [MaxWordBits-1:0] rx_q, rx_d;
  logic [CntW-1:0]        rx_cnt_q, rx_cnt_d;

  logic                   leading;
  logic                   act;
  logic [MaxWordBits-1:0] rx_s;
  logic [CntW-1:0]        rx_c;
  logic [MaxWordBits:0]   rx_ext;
  logic                   done;
  logic [MaxWordBits-1:0] sent;

  always_comb begin
    pol_d     = pol_q;
    pha_d     = pha_q;
    wbits_d   = wbits_q;
    clk_lvl_d = clk_lvl_q;
    mosi_d    = mosi_q;
    miso_d    = miso_q;
    in_word_d = in_word_q;
    tx_d      = tx_q;
    tx_cnt_d  = tx_cnt_q;
    rx_d      = rx_q;
    rx_cnt_d  = rx_cnt_q;
    leading   = 1'b0;
    act       = 1'b0;
    rx_s      = rx_q;
    rx_c      = rx_cnt_q;
    rx_ext    = '0;
    done      = 1'b0;
    sent      = '0;

    if (step_i) begin
      if (spi_lse_pkg::action_e'(action_i) == spi_lse_pkg::ActMosi) begin
        mosi_d = level_i;
      end else if (spi_lse_pkg::action_e'(action_i) == spi_lse_pkg::ActClock &&
                   level_i != clk_lvl_q) begin
        leading   = (level_i != pol_q);
        act       = 1'b1;
        clk_lvl_d = level_i;
        if (!in_word_q) begin
          in_word_d = 1'b1;
          rx_s      = '0;
          rx_c      = '0;
          // phase 1: first edge only opens the word
          if (pha_q) act = 1'b0;
        end
        if (act) begin
          if (leading == !pha_q) begin
            rx_ext = {rx_s, mosi_q};
            rx_s   = rx_ext[MaxWordBits-1:0];
            rx_c   = rx_c + 1'b1;
          end else if (tx_cnt_q != '0) begin
            miso_d   = tx_q[0];
            tx_d     = tx_q >> 1;
            tx_cnt_d = tx_cnt_q - 1'b1;
          end
          if (rx_c == wbits_q) begin
            done      = 1'b1;
            sent      = rx_s;
            tx_d      = reply_word_i;
            tx_cnt_d  = wbits_q;
            in_word_d = 1'b0;
          end
        end
        rx_d     = rx_s;
        rx_cnt_d = rx_c;
      end
    end

    if (cfg_wr_i.en) begin
      unique case (spi_lse_pkg::reg_idx_e'(cfg_wr_i.index))
        spi_lse_pkg::RegPolarity: begin
          pol_d     = cfg_wr_i.data[0];
          clk_lvl_d = cfg_wr_i.data[0];
        end
        spi_lse_pkg::RegPhase:    pha_d   = cfg_wr_i.data[0];
        spi_lse_pkg::RegWordBits: wbits_d = cfg_wr_i.data[CntW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pol_q     <= 1'b0;
      pha_q     <= 1'b0;
      wbits_q   <= spi_lse_pkg::WordBitsReset;
      clk_lvl_q <= 1'b0;
      mosi_q    <= 1'b0;
      miso_q    <= 1'b0;
      in_word_q <= 1'b0;
      tx_q      <= '0;
      tx_cnt_q  <= '0;
      rx_q      <= '0;
      rx_cnt_q  <= '0;
    end else begin
      pol_q     <= pol_d;
      pha_q     <= pha_d;
      wbits_q   <= wbits_d;
      clk_lvl_q <= clk_lvl_d;
      mosi_q    <= mosi_d;
      miso_q    <= miso_d;
      in_word_q <= in_word_d;
      tx_q      <= tx_d;
      tx_cnt_q  <= tx_cnt_d;
      rx_q      <= rx_d;
      rx_cnt_q  <= rx_cnt_d;
    end
  end

  assign miso_level_o = miso_d;
  assign word_done_o  = done;
  assign sent_word_o  = sent;

endmodule

/* rtl/core/spi_pin_level_shift_engine.sv */
// spi slave shift engine driven by pin events, top level with stream ports
// Each request is one pin event (clock level, data-out level or a data-in query) and yields
// one response carrying the data-in pin level after the event. A request is taken every
// cycle while the response register is empty or being drained; the response appears in the
// cycle after acceptance, set by the single response register behind the state update.
// Configuration writes are taken at any time (cfg_ready_o is always high) but are meant
// to happen only while no request is outstanding.
module spi_pin_level_shift_engine #(
  parameter int unsigned MaxWordBits = spi_lse_pkg::MaxWordBitsDefault
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [spi_lse_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [spi_lse_pkg::CfgDataW-1:0]       cfg_data_i,
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  // bit 0 level, then reply_word
  input  logic [((MaxWordBits+8)/8)*8-1:0]       s_axis_tdata,
  // action
  input  logic [spi_lse_pkg::ActionW-1:0]        s_axis_tuser,
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  // bit 0 miso_level, then sent_word
  output logic [((MaxWordBits+8)/8)*8-1:0]       m_axis_tdata,
  // word_done
  output logic                                   m_axis_tuser
);

  spi_lse_pkg::cfg_wr_t cfg_wr;
  logic                   accept;
  logic                   miso;
  logic                   done;
  logic [MaxWordBits-1:0] sent;

  logic                   out_valid_q;
  logic                   out_miso_q;
  logic                   out_done_q;
  logic [MaxWordBits-1:0] out_sent_q;

  assign cfg_ready_o  = 1'b1;
  assign cfg_wr.en    = cfg_valid_i;
  assign cfg_wr.index = cfg_index_i;
  assign cfg_wr.data  = cfg_data_i;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  spi_lse_core #(
    .MaxWordBits(MaxWordBits)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_wr_i    (cfg_wr),
    .step_i      (accept),
    .action_i    (s_axis_tuser),
    .level_i     (s_axis_tdata[0]),
    .reply_word_i(s_axis_tdata[MaxWordBits:1]),
    .miso_level_o(miso),
    .word_done_o (done),
    .sent_word_o (sent)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  // response payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_miso_q <= miso;
      out_done_q <= done;
      out_sent_q <= sent;
    end
  end

  always_comb begin
    m_axis_tdata                = '0;
    m_axis_tdata[0]             = out_miso_q;
    m_axis_tdata[MaxWordBits:1] = out_sent_q;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_done_q;

endmodule

/* verif/testbench.sv */
// self-checking testbench for the spi pin level shift engine
module testbench;
  import spi_lse_pkg::*;

  localparam int unsigned TdW       = ((MaxWordBitsDefault + 8) / 8) * 8;
  localparam int unsigned WordW     = MaxWordBitsDefault;
  localparam int unsigned StallCap  = 2000;
  localparam int unsigned LongHold  = 80;
  localparam int unsigned HoldAfter = 300;

  typedef struct packed {
    action_e          act;
    logic             lvl;
    logic [WordW-1:0] reply;
  } pin_event_t;

  typedef struct packed {
    logic             miso;
    logic             done;
    logic [WordW-1:0] sent;
  } pin_result_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                cfg_valid_i   = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i   = '0;
  logic [CfgDataW-1:0] cfg_data_i    = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [TdW-1:0]      s_axis_tdata  = '0;
  logic [ActionW-1:0]  s_axis_tuser  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [TdW-1:0]      m_axis_tdata;
  logic                m_axis_tuser;

  spi_pin_level_shift_engine uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #10 clk_i = ~clk_i;

  pin_event_t  pending_q[$];
  pin_result_t expected_q[$];
  int          errors   = 0;
  int          n_req    = 0;
  logic        calm     = 1'b0;
  logic        gen_sck  = 1'b0;

  // shadow of the engine state and its registers
  logic             sh_pol    = 1'b0;
  logic             sh_pha    = 1'b0;
  logic [CountW-1:0] sh_nbits = WordBitsReset;
  logic             sh_sck    = 1'b0;
  logic             sh_mosi   = 1'b0;
  logic             sh_miso   = 1'b0;
  logic             sh_active = 1'b0;
  logic [WordW-1:0] sh_txsr   = '0;
  logic [CountW-1:0] sh_txleft = '0;
  logic [WordW-1:0] sh_rxsr   = '0;
  logic [CountW-1:0] sh_rxcnt = '0;

  function automatic pin_result_t shift_engine_step(pin_event_t ev);
    pin_result_t r;
    logic        lead;
    logic        acts;
    r = '0;
    if (ev.act == ActMosi) begin
      sh_mosi = ev.lvl;
    end else if (ev.act == ActClock && ev.lvl != sh_sck) begin
      lead   = (ev.lvl != sh_pol);
      acts   = 1'b1;
      sh_sck = ev.lvl;
      if (!sh_active) begin
        sh_active = 1'b1;
        sh_rxsr   = '0;
        sh_rxcnt  = '0;
        // in phase 1 the opening edge only starts the word
        if (sh_pha) acts = 1'b0;
      end
      if (acts) begin
        if (lead == !sh_pha) begin
          sh_rxsr  = {sh_rxsr[WordW-2:0], sh_mosi};
          sh_rxcnt = sh_rxcnt + 1'b1;
        end else if (sh_txleft != '0) begin
          sh_miso   = sh_txsr[0];
          sh_txsr   = sh_txsr >> 1;
          sh_txleft = sh_txleft - 1'b1;
        end
        if (sh_rxcnt == sh_nbits) begin
          r.done    = 1'b1;
          r.sent    = sh_rxsr;
          sh_txsr   = ev.reply;
          sh_txleft = sh_nbits;
          sh_active = 1'b0;
        end
      end
    end
    r.miso = sh_miso;
    return r;
  endfunction

  // request driver
  int         gap_left;
  logic       tx_quiet;
  pin_event_t next_ev;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      gap_left      <= 0;
      tx_quiet      <= 1'b0;
    end else begin
      if ($urandom_range(0, 39) == 0) tx_quiet <= !tx_quiet;
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left != 0) begin
          gap_left      <= gap_left - 1;
          s_axis_tvalid <= 1'b0;
        end else if (pending_q.size() != 0) begin
          next_ev       = pending_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= TdW'({next_ev.reply, next_ev.lvl});
          s_axis_tuser  <= next_ev.act;
          if (!calm && !tx_quiet && $urandom_range(0, 5) == 0)
            gap_left <= $urandom_range(1, 17);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // response side back-pressure, with one long hold-off to fill the block
  int   stall_left;
  logic rx_quiet;
  logic held;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_left    <= 0;
      rx_quiet      <= 1'b0;
      held          <= 1'b0;
    end else begin
      if ($urandom_range(0, 49) == 0) rx_quiet <= !rx_quiet;
      if (stall_left != 0) begin
        stall_left    <= stall_left - 1;
        m_axis_tready <= 1'b0;
      end else if (!held && n_req >= HoldAfter) begin
        held          <= 1'b1;
        stall_left    <= LongHold;
        m_axis_tready <= 1'b0;
      end else if (!calm && !rx_quiet && $urandom_range(0, 7) == 0) begin
        stall_left    <= $urandom_range(0, 16);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // monitor: register writes and requests feed the shadow, responses are checked
  pin_event_t  seen_ev;
  pin_result_t want;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (reg_idx_e'(cfg_index_i))
          RegPolarity: begin
            sh_pol = cfg_data_i[0];
            sh_sck = cfg_data_i[0];
          end
          RegPhase:    sh_pha   = cfg_data_i[0];
          RegWordBits: sh_nbits = cfg_data_i;
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        seen_ev.act   = action_e'(s_axis_tuser);
        seen_ev.lvl   = s_axis_tdata[0];
        seen_ev.reply = s_axis_tdata[WordW:1];
        expected_q.push_back(shift_engine_step(seen_ev));
        n_req++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_q.size() == 0) begin
          $error("response with no request outstanding: tdata %h tuser %b",
                 m_axis_tdata, m_axis_tuser);
          errors++;
        end else begin
          want = expected_q.pop_front();
          if (m_axis_tdata[0] !== want.miso) begin
            $error("miso_level expected %0d got %0d", want.miso, m_axis_tdata[0]);
            errors++;
          end
          if (m_axis_tuser !== want.done) begin
            $error("word_done expected %0d got %0d", want.done, m_axis_tuser);
            errors++;
          end
          if (m_axis_tdata[WordW:1] !== want.sent) begin
            $error("sent_word expected %h got %h", want.sent, m_axis_tdata[WordW:1]);
            errors++;
          end
        end
      end
    end
  end

  // watchdog on cycles with no handshake at all
  int quiet_cycles = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= StallCap) begin
        $display("FAIL spi_pin_level_shift_engine");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic push_ev(input action_e act, input logic lvl, input logic [WordW-1:0] reply);
    pin_event_t ev;
    ev.act   = act;
    ev.lvl   = lvl;
    ev.reply = reply;
    pending_q.push_back(ev);
  endtask

  task automatic wait_idle();
    do @(posedge clk_i);
    while (pending_q.size() != 0 || s_axis_tvalid || expected_q.size() != 0);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic cfg_beat(input reg_idx_e idx, input logic [CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i);
    while (!cfg_ready_o);
  endtask

  task automatic configure(input logic pol, input logic pha, input logic [CountW-1:0] nbits);
    wait_idle();
    cfg_beat(RegNone, CfgDataW'($urandom()));
    cfg_beat(RegPolarity, {4'($urandom()), pol});
    cfg_beat(RegPhase, {4'($urandom()), pha});
    cfg_beat(RegWordBits, nbits);
    cfg_valid_i <= 1'b0;
    gen_sck = pol;
  endtask

  // mostly clean clock toggles with data changes, plus queries and junk events
  task automatic gen_traffic(input int n);
    pin_event_t ev;
    int         r;
    for (int k = 0; k < n; k++) begin
      r        = $urandom_range(0, 99);
      ev.reply = WordW'($urandom());
      ev.lvl   = 1'($urandom_range(0, 1));
      if (r < 55) begin
        gen_sck = !gen_sck;
        ev.act  = ActClock;
        ev.lvl  = gen_sck;
      end else if (r < 80) begin
        ev.act = ActMosi;
      end else if (r < 88) begin
        ev.act = ActQuery;
      end else if (r < 92) begin
        ev.act = ActRsvd;
      end else if (r < 97) begin
        ev.act = ActClock;
        ev.lvl = gen_sck;
      end else begin
        ev.act  = ActClock;
        gen_sck = ev.lvl;
      end
      pending_q.push_back(ev);
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // one-bit words: completion on every sampling edge
    configure(1'b0, 1'b0, 5'd1);
    push_ev(ActQuery, 1'b0, '0);
    push_ev(ActRsvd, 1'b1, '1);
    push_ev(ActClock, 1'b0, '1);
    push_ev(ActMosi, 1'b1, '0);
    push_ev(ActClock, 1'b1, '1);
    push_ev(ActClock, 1'b0, '0);
    push_ev(ActClock, 1'b0, '0);
    push_ev(ActQuery, 1'b1, '1);
    push_ev(ActClock, 1'b1, '0);
    push_ev(ActMosi, 1'b0, '1);
    push_ev(ActClock, 1'b0, '1);
    push_ev(ActClock, 1'b1, 31'h5555_5555);
    push_ev(ActRsvd, 1'b0, '0);
    push_ev(ActClock, 1'b0, '0);
    push_ev(ActClock, 1'b1, '0);
    push_ev(ActQuery, 1'b0, '0);
    // reply left over and no reply at all with phase 1
    configure(1'b1, 1'b1, 5'd2);
    push_ev(ActMosi, 1'b1, '0);
    push_ev(ActClock, 1'b0, '0);
    push_ev(ActClock, 1'b1, '0);
    push_ev(ActClock, 1'b0, '0);
    push_ev(ActClock, 1'b1, '0);
    push_ev(ActClock, 1'b0, '1);
    push_ev(ActClock, 1'b1, '0);
    push_ev(ActQuery, 1'b0, '0);

    configure(1'b1, 1'b0, 5'd31);
    gen_traffic(110);
    configure(1'b0, 1'b1, 5'd8);
    gen_traffic(110);
    configure(1'b1, 1'b1, 5'd31);
    gen_traffic(110);
    // zero word size: the count has to wrap before a word completes
    configure(1'b0, 1'b0, 5'd0);
    gen_traffic(110);
    configure(1'b1, 1'b0, 5'd3);
    gen_traffic(110);
    configure(1'b0, 1'b1, 5'd1);
    gen_traffic(110);
    configure(1'b1, 1'b1, 5'd0);
    gen_traffic(90);
    configure(1'b0, 1'b0, 5'd5);
    calm <= 1'b1;
    gen_traffic(100);

    wait_idle();
    repeat (5) @(posedge clk_i);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("PASS spi_pin_level_shift_engine");
    end else begin
      $display("FAIL spi_pin_level_shift_engine");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/core/spi_lse_pkg.sv
rtl/core/spi_lse_core.sv
rtl/core/spi_pin_level_shift_engine.sv
verif/testbench.sv
